[hw/rtl/ppid_pkg.sv]
`default_nettype none

package ppid_pkg;

    localparam int DATA_W  = 16;
    localparam int ERR_W   = DATA_W + 1;
    localparam int DIFF_W  = DATA_W + 2;
    localparam int SUM_W   = 32;
    localparam int TOTAL_W = 51;
    localparam int IDX_W   = 3;

    // event codes carried in the input request
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_PWM    = 2'd2
    } op_t;

    // register indexes of the write port
    localparam logic [IDX_W-1:0] REG_SETPOINT   = 3'd0;
    localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 3'd1;
    localparam logic [IDX_W-1:0] REG_INT_GAIN   = 3'd2;
    localparam logic [IDX_W-1:0] REG_DER_GAIN   = 3'd3;
    localparam logic [IDX_W-1:0] REG_PERIOD_TKS = 3'd4;
    localparam logic [IDX_W-1:0] REG_BIAS       = 3'd5;
    localparam logic [IDX_W-1:0] REG_PWM_PERIOD = 3'd6;

    localparam logic [DATA_W-1:0] RST_SETPOINT   = 16'd0;
    localparam logic [DATA_W-1:0] RST_PROP_GAIN  = 16'd256;
    localparam logic [DATA_W-1:0] RST_INT_GAIN   = 16'd0;
    localparam logic [DATA_W-1:0] RST_DER_GAIN   = 16'd0;
    localparam logic [DATA_W-1:0] RST_PERIOD_TKS = 16'd1;
    localparam logic [DATA_W-1:0] RST_BIAS       = 16'd0;
    localparam logic [DATA_W-1:0] RST_PWM_PERIOD = 16'd100;

    typedef struct packed {
        logic signed [DATA_W-1:0] setpoint;
        logic [DATA_W-1:0]        prop_gain;
        logic [DATA_W-1:0]        integral_gain;
        logic [DATA_W-1:0]        derivative_gain;
        logic [DATA_W-1:0]        period_ticks;
        logic [DATA_W-1:0]        output_bias;
        logic [DATA_W-1:0]        pwm_period;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0]        tick_count;
        logic signed [ERR_W-1:0]  prev_error;
        logic signed [SUM_W-1:0]  error_sum;
        logic [DATA_W-1:0]        drive_value;
        logic [DATA_W-1:0]        pwm_counter;
    } state_t;

endpackage

`default_nettype wire

[hw/rtl/ppid_core.sv]
`default_nettype none

// next-state logic for one event: pid terms, clamp, tick and pwm counters
module ppid_core
    import ppid_pkg::*;
(
    input  var cfg_t                     cfg,
    input  var state_t                   cur,
    input  wire logic [1:0]              op,
    input  wire logic signed [DATA_W-1:0] measured,
    output state_t                       nxt,
    output logic                         updated
);

    localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W+1)'({1'b0, {(SUM_W-1){1'b1}}});
    localparam logic signed [SUM_W:0] SUM_MIN = (SUM_W+1)'({2'b11, {(SUM_W-1){1'b0}}});

    logic signed [ERR_W-1:0]       err;
    logic signed [DIFF_W-1:0]      diff;
    logic signed [SUM_W:0]         sum_wide;
    logic signed [SUM_W-1:0]       sum_sat;
    logic signed [ERR_W-1:0]       kp_s;
    logic signed [ERR_W-1:0]       ki_s;
    logic signed [ERR_W-1:0]       kd_s;
    logic signed [ERR_W+ERR_W-1:0] p_term;
    logic signed [ERR_W+SUM_W-1:0] i_term;
    logic signed [ERR_W+DIFF_W-1:0] d_term;
    logic signed [TOTAL_W-1:0]     bias_term;
    logic signed [TOTAL_W-1:0]     limit;
    logic signed [TOTAL_W-1:0]     total;
    logic [DATA_W-1:0]             drive_calc;
    logic [DATA_W-1:0]             pwm_inc;
    logic                          compute;

    assign err  = ERR_W'(cfg.setpoint) - ERR_W'(measured);
    assign diff = DIFF_W'(err) - DIFF_W'(cur.prev_error);

    // saturating error sum
    assign sum_wide = (SUM_W+1)'(cur.error_sum) + (SUM_W+1)'(err);
    always_comb
    begin
        if (sum_wide > SUM_MAX)
            sum_sat = SUM_MAX[SUM_W-1:0];
        else if (sum_wide < SUM_MIN)
            sum_sat = SUM_MIN[SUM_W-1:0];
        else
            sum_sat = sum_wide[SUM_W-1:0];
    end

    assign kp_s = $signed({1'b0, cfg.prop_gain});
    assign ki_s = $signed({1'b0, cfg.integral_gain});
    assign kd_s = $signed({1'b0, cfg.derivative_gain});

    assign p_term = kp_s * err;
    assign i_term = ki_s * sum_sat;
    assign d_term = kd_s * diff;

    assign bias_term = $signed(TOTAL_W'({cfg.output_bias, 8'd0}));
    assign limit     = $signed(TOTAL_W'({cfg.pwm_period, 8'd0}));
    assign total     = TOTAL_W'(p_term) + TOTAL_W'(i_term) + TOTAL_W'(d_term) + bias_term;

    always_comb
    begin
        if (total > limit)
            drive_calc = cfg.pwm_period;
        else if (total < 0)
            drive_calc = cfg.output_bias;
        else
            drive_calc = total[DATA_W+7:8];
    end

    assign compute = (cur.tick_count >= cfg.period_ticks);
    assign pwm_inc = cur.pwm_counter + 1'b1;

    always_comb
    begin
        nxt     = cur;
        updated = 1'b0;
        unique case (op)
            OP_TICK:
            begin
                if (cur.tick_count != {DATA_W{1'b1}})
                    nxt.tick_count = cur.tick_count + 1'b1;
            end
            OP_SAMPLE:
            begin
                if (compute)
                begin
                    nxt.tick_count  = '0;
                    nxt.prev_error  = err;
                    nxt.error_sum   = sum_sat;
                    nxt.drive_value = drive_calc;
                    updated         = 1'b1;
                end
            end
            OP_PWM:
            begin
                nxt.pwm_counter = (pwm_inc > cfg.pwm_period) ? '0 : pwm_inc;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/positional_pid_with_pwm.sv]
// positional pid regulator with a pwm counter. each input request is an
// event in s_tuser: period tick, measurement sample (value in s_tdata) or
// pwm tick; every request yields exactly one result request carrying the
// drive, the pwm pin level and a flag set when a sample ran a pid update.
// one request is taken every clock cycle while results are taken; a
// request lands in the input register at acceptance, and its result is
// loaded into the result register once that slot is free or emptying.
// the rate is set by the state loop: error sum, the three gain
// multiplies, the clamp and the counters are combinational from the
// input register to the state and result registers. registers must be
// written through cfg_we/cfg_index/cfg_data only while the block is
// idle; the block itself does not enforce this. gains are unsigned q8.8,
// bias and periods are plain integers.
// there is no clearing pass after reset.
`default_nettype none

module positional_pid_with_pwm
    import ppid_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              cfg_we,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [DATA_W-1:0] cfg_data,

    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [15:0]       s_tdata,   // [15:0] measured
    input  wire logic [1:0]        s_tuser,   // [1:0] operation

    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [23:0]            m_tdata,   // [15:0] drive, [16] pwm_level, rest zero
    output logic                   m_tuser    // [0] updated
);

    cfg_t                     cfg_reg;
    state_t                   state_reg;
    state_t                   state_next;
    logic                     upd_next;

    // input register
    logic                     in_valid_reg;
    logic [1:0]               in_op_reg;
    logic signed [DATA_W-1:0] in_meas_reg;

    // result register
    logic                     out_valid_reg;
    logic [DATA_W-1:0]        out_drive_reg;
    logic                     out_upd_reg;
    logic                     out_pwm_reg;

    logic                     advance;

    // the input register moves on when the result slot is free or emptying
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint        <= RST_SETPOINT;
            cfg_reg.prop_gain       <= RST_PROP_GAIN;
            cfg_reg.integral_gain   <= RST_INT_GAIN;
            cfg_reg.derivative_gain <= RST_DER_GAIN;
            cfg_reg.period_ticks    <= RST_PERIOD_TKS;
            cfg_reg.output_bias     <= RST_BIAS;
            cfg_reg.pwm_period      <= RST_PWM_PERIOD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SETPOINT:   cfg_reg.setpoint        <= $signed(cfg_data);
                REG_PROP_GAIN:  cfg_reg.prop_gain       <= cfg_data;
                REG_INT_GAIN:   cfg_reg.integral_gain   <= cfg_data;
                REG_DER_GAIN:   cfg_reg.derivative_gain <= cfg_data;
                REG_PERIOD_TKS: cfg_reg.period_ticks    <= cfg_data;
                REG_BIAS:       cfg_reg.output_bias     <= cfg_data;
                REG_PWM_PERIOD: cfg_reg.pwm_period      <= cfg_data;
                default:        cfg_reg                 <= cfg_reg;   // unmapped index
            endcase
        end
    end

    // input register: valid under reset, payload without
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg   <= s_tuser;
            in_meas_reg <= $signed(s_tdata);
        end
    end

    // pid datapath and counters
    ppid_core u_core (
        .cfg      (cfg_reg),
        .cur      (state_reg),
        .op       (in_op_reg),
        .measured (in_meas_reg),
        .nxt      (state_next),
        .updated  (upd_next)
    );

    // controller state, updated once per event as it enters the result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_drive_reg <= state_next.drive_value;
            out_upd_reg   <= upd_next;
            out_pwm_reg   <= (state_next.pwm_counter > state_next.drive_value);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_pwm_reg, out_drive_reg};
    assign m_tuser  = out_upd_reg;

    // input side stalls only while a held item waits behind a stalled result
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

    // a pid update always restarts the control period
    a_tick_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && upd_next) |=> (state_reg.tick_count == '0))
        else $error("tick count not cleared after update");

    // the pwm counter never passes the period after it steps
    a_pwm_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_op_reg == OP_PWM) && !cfg_we)
        |=> (state_reg.pwm_counter <= cfg_reg.pwm_period))
        else $error("pwm counter beyond period");

    // only a sample may report an update
    a_upd_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_op_reg != OP_SAMPLE)) |=> !out_upd_reg)
        else $error("update flagged for a non-sample event");

endmodule

`default_nettype wire
